@@ rtl/core/b2da_pkg.sv @@
// Shared constants for the binary to decimal ASCII converter.
// Used by b2da_dabble and binary_to_decimal_ascii; depends on nothing.
package b2da_pkg;

	// Width of the number that is converted and the decimal digits it can need.
	localparam int NUMBER_BITS = 64;
	localparam int MAX_DIGITS  = 20;
	localparam int BCD_BITS    = MAX_DIGITS * 4;

	// The shift-and-add-three unit takes this many input bits per cycle.
	localparam int BITS_PER_STEP = 8;
	localparam int DABBLE_STEPS  = (64 + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int STEP_W        = (DABBLE_STEPS > 1) ? $clog2(DABBLE_STEPS) : 1;

	// Mask that keeps only the low NUMBER_BITS bits of the input value.
	localparam logic [63:0] VALUE_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUMBER_BITS);

	localparam logic [5:0] ASCII_ZERO    = 6'd48;
	localparam logic [4:0] CAPACITY_INIT = 5'd20;

endpackage

@@ rtl/core/b2da_dabble.sv @@
// Iterative binary to BCD unit (shift and add three), several bits per cycle.
// Depends on b2da_pkg.
module b2da_dabble
	import b2da_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         value,
	output logic                done,
	output logic [BCD_BITS-1:0] bcd
);

	logic [63:0]         bin_q;
	logic [BCD_BITS-1:0] bcd_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [BCD_BITS-1:0] bcd_next;
	logic [63:0]         bin_next;

	// One cycle worth of the shift and add-three recurrence.
	always_comb begin
		logic [BCD_BITS-1:0] t;
		logic [63:0]         b;
		t = bcd_q;
		b = bin_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int n = 0; n < MAX_DIGITS; n++) begin
				if (t[n*4 +: 4] >= 4'd5) begin
					t[n*4 +: 4] = t[n*4 +: 4] + 4'd3;
				end
			end
			t = {t[BCD_BITS-2:0], b[63]};
			b = {b[62:0], 1'b0};
		end
		bcd_next = t;
		bin_next = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DABBLE_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value & VALUE_MASK;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_next;
			bcd_q <= bcd_next;
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

@@ rtl/core/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg and b2da_dabble.
//
// The block takes one unsigned 64-bit value per input beat and returns its
// decimal ASCII digits, most significant first, one output beat per digit.
// Each beat also carries the digit's position counted from the most
// significant digit, the total digit count and a mark on the final beat.
// Zero gives the single digit '0'. When the digit count exceeds the
// configured capacity, or the capacity is zero, a single error beat is sent
// instead: its character and position are zero, total_digits carries the
// true count and too_long and last_digit are set. The capacity register
// resets to 20 and is written through the cfg channel, which is always ready;
// write it only while the converter is idle. One value is converted at a
// time and in_stall stays high until its last beat has been loaded into the
// output register. A value passes through the add-three/shift unit, which
// turns 8 bits per cycle into BCD, then the sizing state, which registers
// the digit count and the error flag, and then the output register, which
// takes one digit beat at a time and holds it while out_stall is high. An
// error value leaves the output register as a single beat.
module binary_to_decimal_ascii
	import b2da_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  digit_char,
	output logic [4:0]  digit_position,
	output logic [4:0]  total_digits,
	output logic        too_long,
	output logic        last_digit,
	// Capacity register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_CONVERT = 2'd1;
	localparam logic [1:0] ST_SIZE    = 2'd2;
	localparam logic [1:0] ST_EMIT    = 2'd3;

	logic [1:0]          state_q;
	logic [4:0]          capacity_q;
	logic                start;
	logic                conv_done;
	logic [BCD_BITS-1:0] bcd;

	// Per-item bookkeeping while digits go out.
	logic [4:0] total_q;
	logic [4:0] pos_q;
	logic [4:0] idx_q;
	logic       err_q;

	// Output register.
	logic       out_valid_q;
	logic [5:0] char_q;
	logic [4:0] opos_q;
	logic [4:0] ototal_q;
	logic       otoo_long_q;
	logic       olast_q;

	logic       slot_free;
	logic [4:0] lead_idx;
	logic [4:0] count;
	logic [6:0] nib_sel;
	logic [3:0] nibble;

	assign in_stall  = (state_q != ST_IDLE);
	assign start     = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || !out_stall;

	b2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// The highest nonzero BCD digit sets the digit count; zero counts as one digit.
	always_comb begin
		lead_idx = '0;
		for (int n = 0; n < MAX_DIGITS; n++) begin
			if (bcd[n*4 +: 4] != 4'd0) begin
				lead_idx = 5'(n);
			end
		end
		count = lead_idx + 5'd1;
	end

	assign nib_sel = {idx_q, 2'b00};
	assign nibble  = bcd[nib_sel +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_INIT;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONVERT;
					end
				end
				ST_CONVERT: begin
					if (conv_done) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (err_q || idx_q == 5'd0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: sizing results and the beat being presented.
	always_ff @(posedge clk) begin
		if (state_q == ST_SIZE) begin
			total_q <= count;
			idx_q   <= lead_idx;
			pos_q   <= '0;
			err_q   <= (capacity_q == 5'd0) || (count > capacity_q);
		end
		if (state_q == ST_EMIT && slot_free) begin
			ototal_q <= total_q;
			if (err_q) begin
				char_q      <= '0;
				opos_q      <= '0;
				otoo_long_q <= 1'b1;
				olast_q     <= 1'b1;
			end else begin
				char_q      <= ASCII_ZERO + {2'b00, nibble};
				opos_q      <= pos_q;
				otoo_long_q <= 1'b0;
				olast_q     <= (idx_q == 5'd0);
				idx_q       <= idx_q - 5'd1;
				pos_q       <= pos_q + 5'd1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign digit_char     = char_q;
	assign digit_position = opos_q;
	assign total_digits   = ototal_q;
	assign too_long       = otoo_long_q;
	assign last_digit     = olast_q;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for binary_to_decimal_ascii.
// It predicts every digit beat from each accepted value and checks the beats in order.
// Depends on b2da_pkg and the RTL of binary_to_decimal_ascii.
`timescale 1ns / 1ps

module tb;
	import b2da_pkg::*;

	// Run-length knobs. The watchdog covers the slowest legal run several
	// times over: about 240 values of up to twenty digits, each digit beat
	// held up by bursts of output stall, plus input gaps and phase pauses.
	localparam int unsigned SETTLE_CYCLES = 30;
	localparam int unsigned DRAIN_LIMIT   = 100000;
	localparam int unsigned RANDOM_BATCH  = 35;
	localparam int unsigned ZERO_CAP_BATCH = 10;

	// One output beat, as the checker sees it.
	typedef struct packed {
		logic [5:0] char_code;
		logic [4:0] position;
		logic [4:0] total;
		logic       over_capacity;
		logic       final_beat;
	} digit_beat_t;

	// Every input of the block holds a known value from time zero.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [63:0] value     = '0;
	logic        out_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [4:0]  cfg_data  = '0;

	logic        in_stall;
	logic        out_valid;
	logic [5:0]  digit_char;
	logic [4:0]  digit_position;
	logic [4:0]  total_digits;
	logic        too_long;
	logic        last_digit;
	logic        cfg_ready;

	// Values waiting to be driven and digit beats the block still owes us.
	logic [63:0]  values_pending [$];
	digit_beat_t  digit_beats_due [$];

	// Our own copy of the capacity register, updated when a write is taken.
	logic [4:0]   capacity_model = CAPACITY_INIT;

	// Idle bursts on both channels are allowed only while this is set.
	logic         bursts_enabled = 1'b0;
	int unsigned  in_gap   = 0;
	int unsigned  out_hold = 0;

	int unsigned  mismatches       = 0;
	int unsigned  values_converted = 0;
	int unsigned  beats_checked    = 0;
	int unsigned  overflow_beats   = 0;
	int unsigned  capacity_writes  = 0;

	// Hand-picked values: zero, the digit-count boundaries at the low end,
	// a power-of-two boundary, the largest 19-digit and smallest 20-digit values,
	// a mixed 20-digit value, the top bit alone, all bits but it, and all ones.
	logic [63:0] boundary_values [13] = '{
		64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1024,
		64'd9999999999999999999, 64'd10000000000000000000,
		64'd12345678901234567890, 64'h8000_0000_0000_0000,
		64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF
	};

	binary_to_decimal_ascii u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_char     (digit_char),
		.digit_position (digit_position),
		.total_digits   (total_digits),
		.too_long       (too_long),
		.last_digit     (last_digit),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #2 clk = ~clk;

	// Works out the digit beats a value must produce under the current
	// capacity. Digits are peeled off by repeated division, least
	// significant first, so zero naturally yields the single digit '0'.
	// A count above the capacity, or a capacity of zero, turns the whole
	// value into one error beat that still reports the true digit count.
	task automatic predict_digits(input logic [63:0] raw);
		logic [63:0] rest;
		logic [3:0]  digits [MAX_DIGITS];
		int unsigned count;
		digit_beat_t beat;
		rest  = raw & VALUE_MASK;
		count = 0;
		do begin
			digits[count] = 4'(rest % 64'd10);
			rest = rest / 64'd10;
			count++;
		end while (rest != 0);
		if (capacity_model == 0 || count > capacity_model) begin
			beat = '{6'd0, 5'd0, 5'(count), 1'b1, 1'b1};
			digit_beats_due.push_back(beat);
		end else begin
			for (int unsigned k = 0; k < count; k++) begin
				beat.char_code     = ASCII_ZERO + 6'(digits[count - 1 - k]);
				beat.position      = 5'(k);
				beat.total         = 5'(count);
				beat.over_capacity = 1'b0;
				beat.final_beat    = (k + 1 == count);
				digit_beats_due.push_back(beat);
			end
		end
	endtask

	// Compares one accepted output beat with the oldest outstanding one.
	task automatic check_beat();
		digit_beat_t got;
		digit_beat_t want;
		got = '{digit_char, digit_position, total_digits, too_long, last_digit};
		beats_checked++;
		if (too_long === 1'b1)
			overflow_beats++;
		if (digit_beats_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: beat with nothing outstanding: char %0d pos %0d total %0d too_long %0b last %0b",
					$realtime, got.char_code, got.position, got.total, got.over_capacity,
					got.final_beat);
		end else begin
			want = digit_beats_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: beat mismatch: expected char %0d pos %0d total %0d too_long %0b last %0b, got char %0d pos %0d total %0d too_long %0b last %0b",
						$realtime, want.char_code, want.position, want.total,
						want.over_capacity, want.final_beat, got.char_code, got.position,
						got.total, got.over_capacity, got.final_beat);
			end
		end
	endtask

	// Random values spread over every bit length, with a share landing
	// right on or next to a power of ten, where the digit count changes.
	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int unsigned width;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			v = '0;
		end else if (pick < 5) begin
			v = 64'd1;
			repeat ($urandom_range(0, 19)) v = v * 64'd10;
			v = v + 64'($urandom_range(0, 2)) - 64'd1;
		end else begin
			width = $urandom_range(1, 64);
			v = {$urandom, $urandom};
			if (width < 64)
				v = v & ((64'd1 << width) - 64'd1);
			v[width - 1] = 1'b1;
		end
		return v;
	endfunction

	// Input driver. A new value is presented once the previous beat is
	// taken (or nothing was offered); a stalled value is held unchanged.
	// Every accepted beat is handed to the predictor at its accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value    <= '0;
			in_gap   <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_digits(value);
				values_converted++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap   <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (values_pending.size() != 0) begin
					value    <= values_pending.pop_front();
					in_valid <= 1'b1;
					if (bursts_enabled && $urandom_range(0, 5) == 0)
						in_gap <= $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor. Checks each accepted beat and throws in bursts of
	// back pressure while bursts are allowed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold  <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (out_hold > 0) begin
				out_hold  <= out_hold - 1;
				out_stall <= 1'b1;
			end else if (bursts_enabled && $urandom_range(0, 9) == 0) begin
				out_hold  <= $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Waits until every queued value is taken and every predicted beat has
	// come out, then lets the block settle before anything else happens.
	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		while ((values_pending.size() != 0 || in_valid || digit_beats_due.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the capacity register; only called while the block is idle.
	task automatic set_capacity(input logic [4:0] cap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_model = cap;
		capacity_writes++;
	endtask

	// Stimulus sequence. A directed pass at the reset capacity comes first,
	// then short directed checks of the error beat at capacities zero and
	// one and of a capacity above twenty. The random phases then walk
	// through several capacities, including both extremes, with the last
	// phase free of any idling so the block runs back to back.
	initial begin
		logic [4:0] phase_caps [7];
		phase_caps = '{5'd19, 5'd0, 5'd12, 5'd3, 5'd31, 5'd7, 5'd20};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		@(negedge clk);
		bursts_enabled = 1'b1;
		foreach (boundary_values[i])
			values_pending.push_back(boundary_values[i]);
		wait_drained();

		// Zero capacity rejects everything, zero included.
		set_capacity(5'd0);
		@(negedge clk);
		values_pending.push_back(64'd0);
		values_pending.push_back(64'd7);
		values_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		wait_drained();

		// A single-digit capacity: the first two-digit value must fail.
		set_capacity(5'd1);
		@(negedge clk);
		values_pending.push_back(64'd0);
		values_pending.push_back(64'd9);
		values_pending.push_back(64'd10);
		values_pending.push_back(64'd42);
		wait_drained();

		// Capacities above twenty never limit anything.
		set_capacity(5'd31);
		@(negedge clk);
		values_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		values_pending.push_back(64'd10000000000000000000);
		wait_drained();

		for (int p = 0; p < 7; p++) begin
			if (p == 5)
				phase_caps[p] = 5'($urandom_range(2, 30));
			set_capacity(phase_caps[p]);
			@(negedge clk);
			bursts_enabled = (p != 6);
			repeat ((phase_caps[p] == 0) ? ZERO_CAP_BATCH : RANDOM_BATCH)
				values_pending.push_back(random_value());
			wait_drained();
		end

		$display("Converted %0d values into %0d checked beats, %0d of them over capacity,",
			values_converted, beats_checked, overflow_beats);
		$display("across %0d capacity writes from zero to thirty-one, with and without stalls.",
			capacity_writes);
		if (mismatches == 0 && digit_beats_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d beats never arrived", mismatches,
				digit_beats_due.size());
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Watchdog expired with %0d beats outstanding", digit_beats_due.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
